@@ design/mie_pkg.sv @@
// ----------------------------------------------------------------------------
// mie_pkg
// Types and constants shared by the modular inverse (extended Euclid) block.
// ----------------------------------------------------------------------------
package mie_pkg;

    localparam int FIELD_W = 31;
    localparam int TDATA_W = 64;
    localparam int PAD_W   = TDATA_W - 2 * FIELD_W;
    localparam int COEF_W  = FIELD_W + 3;
    localparam int SHIFT_W = $clog2(FIELD_W);

    typedef logic [FIELD_W-1:0]        field_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic [SHIFT_W-1:0]        shift_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOINV   = 2'd1,
        STAT_ZEROMOD = 2'd2
    } stat_t;

    typedef struct packed {
        logic   zero_mod;
        field_t gcd;
        field_t modulus;
        coef_t  coef;
    } euc_res_t;

endpackage

@@ design/mie_euclid.sv @@
// ----------------------------------------------------------------------------
// mie_euclid
// Iterative extended Euclid core: shift-and-subtract division, one quotient
// bit per cycle, with the Bezout coefficient updated alongside.
// ----------------------------------------------------------------------------
module mie_euclid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mie_pkg::field_t   value,
    input  mie_pkg::field_t   modulus,
    input  logic              release_res,
    output logic              idle,
    output logic              done,
    output mie_pkg::euc_res_t res
);
    import mie_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ALIGN = 4'b0010,
        S_SUB   = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    field_t ra_reg, ra_next;
    field_t rb_reg, rb_next;
    field_t d_reg, d_next;
    field_t mod_reg, mod_next;
    coef_t  ca_reg, ca_next;
    coef_t  cb_reg, cb_next;
    coef_t  c_reg, c_next;
    shift_t sh_reg, sh_next;
    logic   zmod_reg, zmod_next;

    logic   can_up;
    logic   ge;
    field_t r_new;
    coef_t  c_new;

    always_comb
    begin
        can_up = ({d_reg, 1'b0} <= {1'b0, ra_reg});
        ge     = (ra_reg >= d_reg);
        r_new  = ge ? (ra_reg - d_reg) : ra_reg;
        c_new  = ge ? (ca_reg - c_reg) : ca_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        d_next     = d_reg;
        mod_next   = mod_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        c_next     = c_reg;
        sh_next    = sh_reg;
        zmod_next  = zmod_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mod_next = modulus;
                    ra_next  = value;
                    rb_next  = modulus;
                    d_next   = modulus;
                    ca_next  = coef_t'(1);
                    cb_next  = '0;
                    c_next   = '0;
                    sh_next  = '0;
                    if (modulus == '0)
                    begin
                        zmod_next  = 1'b1;
                        ra_next    = '0;
                        ca_next    = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        zmod_next  = 1'b0;
                        state_next = S_ALIGN;
                    end
                end
            end
            S_ALIGN:
            begin
                if (can_up)
                begin
                    d_next  = {d_reg[FIELD_W-2:0], 1'b0};
                    c_next  = c_reg <<< 1;
                    sh_next = sh_reg + shift_t'(1);
                end
                else
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                ra_next = r_new;
                ca_next = c_new;
                if (sh_reg == '0)
                begin
                    ra_next = rb_reg;
                    rb_next = r_new;
                    ca_next = cb_reg;
                    cb_next = c_new;
                    d_next  = r_new;
                    c_next  = c_new;
                    if (r_new == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ALIGN;
                    end
                end
                else
                begin
                    d_next  = {1'b0, d_reg[FIELD_W-1:1]};
                    c_next  = c_reg >>> 1;
                    sh_next = sh_reg - shift_t'(1);
                end
            end
            S_DONE:
            begin
                if (release_res)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        d_reg    <= d_next;
        mod_reg  <= mod_next;
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        c_reg    <= c_next;
        sh_reg   <= sh_next;
        zmod_reg <= zmod_next;
    end

    assign idle         = (state_reg == S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign res.zero_mod = zmod_reg;
    assign res.gcd      = ra_reg;
    assign res.modulus  = mod_reg;
    assign res.coef     = ca_reg;

endmodule

@@ design/mie_fold.sv @@
// ----------------------------------------------------------------------------
// mie_fold
// Status decode and folding of the Bezout coefficient into 0..modulus-1.
// ----------------------------------------------------------------------------
module mie_fold
(
    input  mie_pkg::euc_res_t res,
    output mie_pkg::field_t   inverse,
    output mie_pkg::field_t   divisor,
    output mie_pkg::stat_t    status
);
    import mie_pkg::*;

    coef_t sum;

    always_comb
    begin
        sum = res.coef + coef_t'({{(COEF_W-FIELD_W){1'b0}}, res.modulus});
        if (res.zero_mod)
        begin
            inverse = '0;
            divisor = '0;
            status  = STAT_ZEROMOD;
        end
        else if (res.gcd != field_t'(1))
        begin
            inverse = '0;
            divisor = res.gcd;
            status  = STAT_NOINV;
        end
        else
        begin
            inverse = res.coef[COEF_W-1] ? sum[FIELD_W-1:0] : res.coef[FIELD_W-1:0];
            divisor = res.gcd;
            status  = STAT_OK;
        end
    end

endmodule

@@ design/modular_inverse_ext_euclid_top.sv @@
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_top
// Modular inverse and gcd of a value against a modulus by extended Euclid.
//
// Channel   Dir  Payload
// s_*       in   tdata: value[30:0], modulus[61:31]
// m_*       out  tdata: inverse[30:0], divisor[61:31]; tuser: status[1:0]
//
// The core works on one item at a time. In each Euclid step it shifts the
// divisor up to align it with the remainder, ends the alignment, and then
// subtracts once per quotient bit while shifting the divisor back down. A
// zero modulus skips the steps and goes straight to the result.
// A new beat is taken as soon as the core is idle, even while a result
// waits in the output register. rst_n clears the control state at once.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mie_pkg::TDATA_W-1:0] s_tdata,   // value, modulus
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mie_pkg::TDATA_W-1:0] m_tdata,   // inverse, divisor
    output logic [1:0]                  m_tuser    // status
);
    import mie_pkg::*;

    logic     core_idle;
    logic     core_done;
    logic     load;
    euc_res_t res;
    field_t   f_inv;
    field_t   f_div;
    stat_t    f_stat;

    logic     valid_reg, valid_next;
    field_t   inv_reg;
    field_t   div_reg;
    stat_t    stat_reg;

    mie_euclid u_euclid
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (s_tvalid && s_tready),
        .value       (s_tdata[FIELD_W-1:0]),
        .modulus     (s_tdata[2*FIELD_W-1:FIELD_W]),
        .release_res (load),
        .idle        (core_idle),
        .done        (core_done),
        .res         (res)
    );

    mie_fold u_fold
    (
        .res     (res),
        .inverse (f_inv),
        .divisor (f_div),
        .status  (f_stat)
    );

    assign s_tready = core_idle;
    assign load     = core_done && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            inv_reg  <= f_inv;
            div_reg  <= f_div;
            stat_reg <= f_stat;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, div_reg, inv_reg};
    assign m_tuser  = stat_reg;

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for modular_inverse_ext_euclid_top.
//
// Operand pairs go in on the slave stream. Each accepted beat is run through
// a local extended Euclid predictor, and the inverse, gcd and status it gives
// are queued. Every beat taken from the master stream is checked against the
// oldest queued result. The stimulus has directed corner cases, then random
// pairs of several kinds. Both streams idle at random, and one phase runs
// with no idling. During one long hold-off on the master side, the sender
// keeps offering beats so that the block fills up.
// ----------------------------------------------------------------------------
module testbench;

    import mie_pkg::*;

    typedef struct {
        field_t inverse;
        field_t divisor;
        stat_t  status;
    } inv_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;

    inv_result_t pending_results[$];
    int          mismatch_count;
    bit          idle_on;
    bit          hold_request;

    modular_inverse_ext_euclid_top i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #30_000_000;
        $display("modular_inverse_ext_euclid_top test failed");
        $finish;
    end

    function automatic inv_result_t predict_inverse(input field_t value, input field_t modulus);
        inv_result_t res;
        logic [63:0] val;
        logic [63:0] md;
        logic [63:0] rem_a;
        logic [63:0] rem_b;
        logic [63:0] co_a;
        logic [63:0] co_b;
        logic [63:0] quot;
        logic [63:0] tmp;
        int          k;
        val = 64'(value);
        md  = 64'(modulus);
        res.inverse = '0;
        res.divisor = '0;
        res.status  = STAT_ZEROMOD;
        if (md == 64'd0)
        begin
            return res;
        end
        if (val > md)
        begin
            val = val % md;
        end
        rem_a = val;
        rem_b = md;
        co_a  = 64'd1;
        co_b  = 64'd0;
        for (k = 0; k < 64 && rem_b != 64'd0; k++)
        begin
            quot  = rem_a / rem_b;
            tmp   = rem_a - quot * rem_b;
            rem_a = rem_b;
            rem_b = tmp;
            tmp   = co_a - quot * co_b;
            co_a  = co_b;
            co_b  = tmp;
        end
        res.divisor = rem_a[FIELD_W-1:0];
        if (rem_a != 64'd1)
        begin
            res.status = STAT_NOINV;
            return res;
        end
        if (co_a[63])
        begin
            tmp = (64'd0 - co_a) % md;
            tmp = (tmp == 64'd0) ? 64'd0 : md - tmp;
        end
        else
        begin
            tmp = co_a % md;
        end
        res.inverse = tmp[FIELD_W-1:0];
        res.status  = STAT_OK;
        return res;
    endfunction

    // enter and leave at a falling edge
    task automatic send_operands(input field_t value, input field_t modulus);
        if (idle_on && $urandom_range(99) < 10)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, modulus, value};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_results.push_back(predict_inverse(value, modulus));
        @(negedge clk);
    endtask

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (399) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                m_tready <= !(idle_on && $urandom_range(99) < 10);
            end
        end
    end

    always @(posedge clk)
    begin
        inv_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: tdata %h tuser %0d", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata[FIELD_W-1:0] !== exp_res.inverse)
                begin
                    $error("inverse: expected %0d, got %0d",
                           exp_res.inverse, m_tdata[FIELD_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[2*FIELD_W-1:FIELD_W] !== exp_res.divisor)
                begin
                    $error("divisor: expected %0d, got %0d",
                           exp_res.divisor, m_tdata[2*FIELD_W-1:FIELD_W]);
                    mismatch_count++;
                end
                if (m_tuser !== 2'(exp_res.status))
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_random_pair();
        int unsigned g;
        int unsigned a;
        int unsigned b;
        field_t      value;
        field_t      modulus;
        value   = field_t'($urandom());
        modulus = field_t'($urandom());
        case ($urandom_range(99)) inside
            [0:49]:  ;
            [50:64]:
            begin
                value   = field_t'($urandom_range(0, 255));
                modulus = field_t'($urandom_range(1, 255));
            end
            [65:79]:
            begin
                g = $urandom_range(2, 1000);
                a = $urandom_range(0, 32'h7FFF_FFFF / g);
                b = $urandom_range(1, 32'h7FFF_FFFF / g);
                value   = field_t'(a * g);
                modulus = field_t'(b * g);
            end
            [80:87]: value = modulus;
            [88:93]: modulus = field_t'($urandom_range(0, 3));
            default: modulus = field_t'($urandom_range(1, 1 << $urandom_range(1, 30)));
        endcase
        send_operands(value, modulus);
    endtask

    task automatic test_directed_cases();
        send_operands(31'd0, 31'd0);
        send_operands(31'h7FFF_FFFF, 31'd0);
        send_operands(31'd1, 31'd1);
        send_operands(31'd0, 31'd1);
        send_operands(31'h7FFF_FFFF, 31'd1);
        send_operands(31'd0, 31'd7);
        send_operands(31'd7, 31'd7);
        send_operands(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_operands(31'd6, 31'd9);
        send_operands(31'd3, 31'd7);
        send_operands(31'd10, 31'd7);
        send_operands(31'd1, 31'h7FFF_FFFF);
        send_operands(31'h7FFF_FFFE, 31'h7FFF_FFFF);
        send_operands(31'h7FFF_FFFF, 31'h7FFF_FFFE);
        send_operands(31'd1134903170, 31'd1836311903);
        send_operands(31'd1836311903, 31'd1134903170);
        send_operands(31'h5555_5555, 31'h2AAA_AAAA);
        send_operands(31'h2AAA_AAAA, 31'h5555_5555);
        send_operands(31'h4000_0000, 31'h7FFF_FFFF);
        send_operands(31'h4000_0000, 31'h2000_0000);
        send_operands(31'd2, 31'h7FFF_FFFE);
        send_operands(31'd65537, 31'd4294967);
    endtask

    task automatic test_random_operands(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_random_pair();
        end
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        for (int n = 0; n < 120; n++)
        begin
            send_random_pair();
        end
    endtask

    initial
    begin
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        rst_n          = 1'b0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        hold_request   = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_random_operands(1000);
        idle_on = 1'b0;
        test_random_operands(300);
        idle_on = 1'b1;
        test_output_backpressure();
        test_random_operands(410);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("modular_inverse_ext_euclid_top test passed");
        end
        else
        begin
            $display("modular_inverse_ext_euclid_top test failed");
        end
        $finish;
    end

endmodule
